// ===== rtl/rbt_pkg.sv =====
// Package for the register binding table: request and status codes,
// configuration register indexes and the command/status structs of the cells.
// Has no dependencies; every other file in rtl refers to it by scoped names.
package rbt_pkg;

    // Width of a register number on the ports.
    localparam int REG_IDX_W = 5;
    // Width of the reserved mask and of the configuration data.
    localparam int MASK_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Request codes carried on the input channel.
    typedef enum logic [3:0] {
        REQ_INIT   = 4'd0,
        REQ_ALLOC  = 4'd1,
        REQ_FREE   = 4'd2,
        REQ_FIND   = 4'd3,
        REQ_BIND   = 4'd4,
        REQ_FORGET = 4'd5,
        REQ_CLEAR  = 4'd6,
        REQ_DIRTY  = 4'd7,
        REQ_QUERY  = 4'd8
    } req_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_OUT     = 2'd2
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_GENERAL = 2'd0,
        CFG_LAST_GENERAL  = 2'd1,
        CFG_RESERVED_MASK = 2'd2
    } cfg_idx_t;

    // Command broadcast to every cell in the row.
    typedef struct packed {
        logic                 fire;
        req_t                 op;
        logic [REG_IDX_W-1:0] reg_index;
    } cell_cmd_t;

    // Per-cell flags and responses seen by the top level.
    typedef struct packed {
        logic used;
        logic bound;
        logic dirty;
        logic win;
        logic q_hit;
    } cell_stat_t;

endpackage

// ===== rtl/rbt_cell.sv =====
// One entry of the register binding table: used, bound and dirty flags and
// the bound address, plus the priority link to its neighbor in the row.
// Depends on rbt_pkg.
module rbt_cell #(
    parameter int IDX       = 0,
    parameter int ADDR_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rbt_pkg::cell_cmd_t     cmd,
    input  logic [ADDR_BITS-1:0]   mem_addr,
    input  logic                   gen,
    input  logic                   rsv,
    input  logic                   take_in,
    output logic                   take_out,
    output rbt_pkg::cell_stat_t    stat,
    output logic [ADDR_BITS-1:0]   addr
);

    logic                 used_reg, used_next;
    logic                 bound_reg, bound_next;
    logic                 dirty_reg, dirty_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic                 sel;
    logic                 sel_gen;
    logic                 match;
    logic                 hit;
    logic                 win;

    // Local decode: is this cell named, and does its binding match the address.
    assign sel     = (int'(cmd.reg_index) == IDX);
    assign sel_gen = sel && gen;
    assign match   = bound_reg && (addr_reg == mem_addr);

    // Candidate for the lowest-index search; the first candidate in the row wins.
    always_comb begin
        hit = 1'b0;
        if (cmd.op == rbt_pkg::REQ_ALLOC) begin
            hit = gen && !used_reg;
        end else if (cmd.op == rbt_pkg::REQ_FIND) begin
            hit = gen && !used_reg && match && !dirty_reg;
        end
    end

    assign win      = hit && !take_in;
    assign take_out = take_in || hit;

    // Next entry state for the request in flight.
    always_comb begin
        used_next  = used_reg;
        bound_next = bound_reg;
        dirty_next = dirty_reg;
        addr_next  = addr_reg;
        if (cmd.fire) begin
            unique case (cmd.op)
                rbt_pkg::REQ_INIT: begin
                    used_next  = rsv;
                    bound_next = 1'b0;
                    dirty_next = 1'b0;
                end
                rbt_pkg::REQ_ALLOC: begin
                    if (win) begin
                        used_next  = 1'b1;
                        bound_next = 1'b0;
                        dirty_next = 1'b0;
                    end
                end
                rbt_pkg::REQ_FREE: begin
                    if (sel_gen) begin
                        used_next = 1'b0;
                    end
                end
                rbt_pkg::REQ_FIND: begin
                    if (win) begin
                        used_next = 1'b1;
                    end
                end
                rbt_pkg::REQ_BIND: begin
                    if (sel_gen) begin
                        bound_next = 1'b1;
                        addr_next  = mem_addr;
                        dirty_next = 1'b0;
                    end
                end
                rbt_pkg::REQ_FORGET: begin
                    if (gen && match) begin
                        bound_next = 1'b0;
                        dirty_next = 1'b0;
                    end
                end
                rbt_pkg::REQ_CLEAR: begin
                    if (sel_gen) begin
                        bound_next = 1'b0;
                    end
                end
                rbt_pkg::REQ_DIRTY: begin
                    if (sel_gen) begin
                        dirty_next = 1'b1;
                        bound_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Flags reset to clear; the address is only seen while bound.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= 1'b0;
            bound_reg <= 1'b0;
            dirty_reg <= 1'b0;
        end else begin
            used_reg  <= used_next;
            bound_reg <= bound_next;
            dirty_reg <= dirty_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
    end

    // Status toward the top level.
    assign stat.used  = used_reg;
    assign stat.bound = bound_reg;
    assign stat.dirty = dirty_reg;
    assign stat.win   = win;
    assign stat.q_hit = sel_gen && (cmd.op == rbt_pkg::REQ_QUERY);
    assign addr       = addr_reg;

endmodule

// ===== rtl/register_binding_table_top.sv =====
// Register binding table, top level: configuration registers, the row of
// cells and the result register. Depends on rbt_pkg and rbt_cell.

// The table takes one request per clock cycle and registers its result in the
// output register of the result channel; a new request is accepted whenever that
// register is empty or being read in the same cycle. Each table entry lives in
// its own cell, and every cell updates in parallel on an accepted request.
// Alloc and find pick the lowest qualifying register through a take chain that
// runs from cell 0 up the row, so the longest path grows with NUM_REGS.
// Configuration writes are always accepted; the general range and reserved
// mask take effect for the next request, and the reserved mask only on init.
module register_binding_table_top #(
    parameter int NUM_REGS  = 32,
    parameter int ADDR_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbt_pkg::MASK_W-1:0]      cfg_data,
    // Request channel.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [3:0]                      s_req_type,
    input  logic [rbt_pkg::REG_IDX_W-1:0]   s_reg_index,
    input  logic [ADDR_BITS-1:0]            s_mem_addr,
    // Result channel.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [rbt_pkg::REG_IDX_W-1:0]   m_reg_out,
    output logic [ADDR_BITS-1:0]            m_addr_out,
    output logic                            m_addr_bound,
    output logic                            m_dirty_out,
    output logic                            m_is_general
);

    logic [rbt_pkg::REG_IDX_W-1:0] first_general_reg;
    logic [rbt_pkg::REG_IDX_W-1:0] last_general_reg;
    logic [rbt_pkg::MASK_W-1:0]    reserved_mask_reg;

    logic                            m_valid_reg;
    rbt_pkg::status_t                status_reg, status_next;
    logic [rbt_pkg::REG_IDX_W-1:0]   reg_out_reg, reg_out_next;
    logic [ADDR_BITS-1:0]            addr_out_reg, addr_out_next;
    logic                            addr_bound_reg, addr_bound_next;
    logic                            dirty_out_reg, dirty_out_next;
    logic                            is_general_reg, is_general_next;

    logic                            s_fire;
    rbt_pkg::req_t                   op;
    rbt_pkg::cell_cmd_t              cmd;
    logic [NUM_REGS-1:0]             gen_vec;
    logic [NUM_REGS-1:0]             rsv_vec;
    logic [NUM_REGS:0]               take;
    rbt_pkg::cell_stat_t             stat_arr [NUM_REGS];
    logic [ADDR_BITS-1:0]            addr_arr [NUM_REGS];

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_general_reg <= '0;
            last_general_reg  <= '1;
            reserved_mask_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (rbt_pkg::cfg_idx_t'(cfg_index))
                rbt_pkg::CFG_FIRST_GENERAL: begin
                    first_general_reg <= cfg_data[rbt_pkg::REG_IDX_W-1:0];
                end
                rbt_pkg::CFG_LAST_GENERAL: begin
                    last_general_reg <= cfg_data[rbt_pkg::REG_IDX_W-1:0];
                end
                rbt_pkg::CFG_RESERVED_MASK: begin
                    reserved_mask_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Request handshake and the command broadcast to the cells.
    assign s_ready       = !m_valid_reg || m_ready;
    assign s_fire        = s_valid && s_ready;
    assign op            = rbt_pkg::req_t'(s_req_type);
    assign cmd.fire      = s_fire;
    assign cmd.op        = op;
    assign cmd.reg_index = s_reg_index;

    // General range and reserved bits per cell; indexes past the mask never qualify.
    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            gen_vec[i] = (i < rbt_pkg::MASK_W) && (i >= int'(first_general_reg))
                         && (i <= int'(last_general_reg));
            rsv_vec[i] = (i < rbt_pkg::MASK_W) ? reserved_mask_reg[i % rbt_pkg::MASK_W]
                                               : 1'b0;
        end
    end

    // Row of cells linked by the take chain.
    assign take[0] = 1'b0;

    for (genvar g = 0; g < NUM_REGS; g++) begin : g_cell
        rbt_cell #(
            .IDX       (g),
            .ADDR_BITS (ADDR_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .mem_addr (s_mem_addr),
            .gen      (gen_vec[g]),
            .rsv      (rsv_vec[g]),
            .take_in  (take[g]),
            .take_out (take[g+1]),
            .stat     (stat_arr[g]),
            .addr     (addr_arr[g])
        );
    end

    // Result for the request in flight: winner number and one-hot query select.
    always_comb begin
        status_next     = rbt_pkg::ST_OK;
        reg_out_next    = '0;
        addr_out_next   = '0;
        addr_bound_next = 1'b0;
        dirty_out_next  = 1'b0;
        is_general_next = 1'b0;
        for (int i = 0; i < NUM_REGS; i++) begin
            if (stat_arr[i].win) begin
                reg_out_next = reg_out_next | rbt_pkg::REG_IDX_W'(i);
            end
            if (stat_arr[i].q_hit) begin
                is_general_next = 1'b1;
                dirty_out_next  = dirty_out_next | stat_arr[i].dirty;
                addr_bound_next = addr_bound_next | stat_arr[i].bound;
                if (stat_arr[i].bound) begin
                    addr_out_next = addr_out_next | addr_arr[i];
                end
            end
        end
        if (!take[NUM_REGS]) begin
            if (op == rbt_pkg::REQ_ALLOC) begin
                status_next = rbt_pkg::ST_OUT;
            end else if (op == rbt_pkg::REQ_FIND) begin
                status_next = rbt_pkg::ST_NOMATCH;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg     <= status_next;
            reg_out_reg    <= reg_out_next;
            addr_out_reg   <= addr_out_next;
            addr_bound_reg <= addr_bound_next;
            dirty_out_reg  <= dirty_out_next;
            is_general_reg <= is_general_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_reg_out    = reg_out_reg;
    assign m_addr_out   = addr_out_reg;
    assign m_addr_bound = addr_bound_reg;
    assign m_dirty_out  = dirty_out_reg;
    assign m_is_general = is_general_reg;

    // At most one cell wins the lowest-index search.
    logic [NUM_REGS-1:0] win_vec;
    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            win_vec[i] = stat_arr[i].win;
        end
    end

    a_win_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(win_vec))
        else $error("more than one cell won the search");

    a_win_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (|win_vec) |-> (op == rbt_pkg::REQ_ALLOC || op == rbt_pkg::REQ_FIND))
        else $error("search winner outside alloc or find");

    a_alloc_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && op == rbt_pkg::REQ_ALLOC && (|win_vec))
        |=> (m_status == rbt_pkg::ST_OK && m_valid))
        else $error("alloc with a free register did not report ok");

    a_query_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && op != rbt_pkg::REQ_QUERY)
        |=> (!m_is_general && !m_addr_bound && !m_dirty_out && m_addr_out == '0))
        else $error("query fields set on a non-query transaction");

endmodule

// ===== bench/tb_register_binding_table_top.sv =====
`timescale 1ns / 100ps
// Testbench for register_binding_table_top: random and directed request traffic
// checked against a bit-accurate table model kept in a scoreboard class.
// Depends on rbt_pkg and the register binding table RTL.
module tb_register_binding_table_top;
    import rbt_pkg::*;

    localparam int NUM_REGS = 32;
    localparam int ADDR_W   = 16;

    // One result transaction as seen on the m_ channel.
    typedef struct packed {
        logic [1:0]          status;
        logic [4:0]          reg_out;
        logic [ADDR_W-1:0]   addr_out;
        logic                addr_bound;
        logic                dirty_out;
        logic                is_general;
    } table_result_t;

    // Scoreboard: tracks the table contents and the configuration, predicts the
    // result of each accepted request and checks the results in order.
    class binding_scoreboard;
        logic [4:0]        first_gen;
        logic [4:0]        last_gen;
        logic [31:0]       resv_mask;
        bit                used_f[NUM_REGS];
        bit                bound_f[NUM_REGS];
        logic [ADDR_W-1:0] bound_a[NUM_REGS];
        bit                dirty_f[NUM_REGS];
        table_result_t     expected_results[$];
        logic [4:0]        last_pick;
        logic [1:0]        last_status;
        int                errors;

        function new();
            first_gen = 5'd0;
            last_gen  = 5'd31;
            resv_mask = '0;
            errors    = 0;
            last_pick = '0;
            last_status = ST_OK;
            for (int i = 0; i < NUM_REGS; i++) begin
                used_f[i]  = 0;
                bound_f[i] = 0;
                bound_a[i] = '0;
                dirty_f[i] = 0;
            end
        endfunction

        function bit general(int r);
            return r < NUM_REGS && r >= first_gen && r <= last_gen;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_config(cfg_idx_t idx, logic [31:0] data);
            case (idx)
                CFG_FIRST_GENERAL: first_gen = data[4:0];
                CFG_LAST_GENERAL:  last_gen  = data[4:0];
                CFG_RESERVED_MASK: resv_mask = data;
                default: ;
            endcase
        endfunction

        // Apply one accepted request to the table and queue its result.
        function void note_request(logic [3:0] req, logic [4:0] r, logic [ADDR_W-1:0] a);
            table_result_t res;
            res = '0;
            res.status = ST_OK;
            case (req)
                REQ_INIT: begin
                    for (int i = 0; i < NUM_REGS; i++) begin
                        used_f[i]  = resv_mask[i];
                        bound_f[i] = 0;
                        bound_a[i] = '0;
                        dirty_f[i] = 0;
                    end
                end
                REQ_ALLOC: begin
                    res.status = ST_OUT;
                    for (int i = 0; i < NUM_REGS; i++) begin
                        if (general(i) && !used_f[i]) begin
                            used_f[i]  = 1;
                            bound_f[i] = 0;
                            bound_a[i] = '0;
                            dirty_f[i] = 0;
                            res.status  = ST_OK;
                            res.reg_out = i[4:0];
                            break;
                        end
                    end
                end
                REQ_FREE: begin
                    if (general(r)) used_f[r] = 0;
                end
                REQ_FIND: begin
                    // Only a free, clean, bound entry holding the address qualifies.
                    res.status = ST_NOMATCH;
                    for (int i = 0; i < NUM_REGS; i++) begin
                        if (general(i) && !used_f[i] && bound_f[i] &&
                                bound_a[i] == a && !dirty_f[i]) begin
                            used_f[i]   = 1;
                            res.status  = ST_OK;
                            res.reg_out = i[4:0];
                            break;
                        end
                    end
                end
                REQ_BIND: begin
                    if (general(r)) begin
                        bound_f[r] = 1;
                        bound_a[r] = a;
                        dirty_f[r] = 0;
                    end
                end
                REQ_FORGET: begin
                    for (int i = 0; i < NUM_REGS; i++) begin
                        if (general(i) && bound_f[i] && bound_a[i] == a) begin
                            bound_f[i] = 0;
                            bound_a[i] = '0;
                            dirty_f[i] = 0;
                        end
                    end
                end
                REQ_CLEAR: begin
                    if (general(r)) begin
                        bound_f[r] = 0;
                        bound_a[r] = '0;
                    end
                end
                REQ_DIRTY: begin
                    if (general(r)) begin
                        dirty_f[r] = 1;
                        bound_f[r] = 0;
                        bound_a[r] = '0;
                    end
                end
                REQ_QUERY: begin
                    if (general(r)) begin
                        res.is_general = 1'b1;
                        res.dirty_out  = dirty_f[r];
                        if (bound_f[r]) begin
                            res.addr_bound = 1'b1;
                            res.addr_out   = bound_a[r];
                        end
                    end
                end
                default: ;
            endcase
            last_pick   = res.reg_out;
            last_status = res.status;
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                $error("%s: expected %0d, actual %0d", name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(table_result_t got);
            table_result_t exp;
            if (expected_results.size() == 0) begin
                $error("result transaction with no request outstanding");
                errors++;
                return;
            end
            exp = expected_results.pop_front();
            compare_field("status", exp.status, got.status);
            compare_field("reg_out", exp.reg_out, got.reg_out);
            compare_field("addr_out", exp.addr_out, got.addr_out);
            compare_field("addr_bound", exp.addr_bound, got.addr_bound);
            compare_field("dirty_out", exp.dirty_out, got.dirty_out);
            compare_field("is_general", exp.is_general, got.is_general);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [MASK_W-1:0]     cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [3:0]            s_req_type;
    logic [REG_IDX_W-1:0]  s_reg_index;
    logic [ADDR_W-1:0]     s_mem_addr;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_status;
    logic [REG_IDX_W-1:0]  m_reg_out;
    logic [ADDR_W-1:0]     m_addr_out;
    logic                  m_addr_bound;
    logic                  m_dirty_out;
    logic                  m_is_general;

    binding_scoreboard table_sb = new();

    // Sender burst state and the address pool that makes lookups hit.
    int                burst_left = 0;
    logic [ADDR_W-1:0] addr_pool[8];

    register_binding_table_top #(
        .NUM_REGS  (NUM_REGS),
        .ADDR_BITS (ADDR_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_reg_index  (s_reg_index),
        .s_mem_addr   (s_mem_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_reg_out    (m_reg_out),
        .m_addr_out   (m_addr_out),
        .m_addr_bound (m_addr_bound),
        .m_dirty_out  (m_dirty_out),
        .m_is_general (m_is_general)
    );

    // 8 ns clock.
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Hard limit on the run time.
    initial begin
        #4000000;
        $display("register_binding_table_top test failed");
        $finish;
    end

    // Check every result transaction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            table_sb.check_result('{m_status, m_reg_out, m_addr_out,
                                    m_addr_bound, m_dirty_out, m_is_general});
        end
    end

    // Result receiver: a long hold-off first so the block backs up, then a mix
    // of open stretches, random stalls, a periodic pattern and long holds.
    initial begin : receiver
        int mode;
        int len;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        repeat (80) @(posedge aclk);
        forever begin
            mode = $urandom_range(0, 9);
            len  = $urandom_range(4, 40);
            for (int k = 0; k < len; k++) begin
                case (mode)
                    0, 1, 2, 3: m_ready <= 1'b1;
                    4, 5, 6, 7: m_ready <= ($urandom_range(0, 3) != 0);
                    8:          m_ready <= (k % 3 == 0);
                    default:    m_ready <= 1'b0;
                endcase
                @(posedge aclk);
            end
        end
    end

    // One configuration write; cfg_valid stays up for a following write.
    task automatic write_cfg(cfg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        table_sb.note_config(idx, data);
    endtask

    task automatic set_config(logic [4:0] first, logic [4:0] last, logic [31:0] mask);
        write_cfg(CFG_FIRST_GENERAL, {27'd0, first});
        write_cfg(CFG_LAST_GENERAL, {27'd0, last});
        write_cfg(CFG_RESERVED_MASK, mask);
        cfg_valid <= 1'b0;
    endtask

    // Offer one request and wait for the transaction; a burst ends in a gap.
    task automatic send_req(logic [3:0] req, logic [4:0] r, logic [ADDR_W-1:0] a);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_reg_index <= r;
        s_mem_addr  <= a;
        do @(posedge aclk); while (!s_ready);
        table_sb.note_request(req, r, a);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (table_sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    function automatic logic [4:0] rand_reg();
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 9) < 7 && table_sb.first_gen <= table_sb.last_gen)
            return 5'($urandom_range(table_sb.first_gen, table_sb.last_gen));
        return rand_reg();
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(0, 9) < 7)
            return addr_pool[$urandom_range(0, 7)];
        return rand_addr();
    endfunction

    // Allocate, bind, release and reclaim a register, with some disturbance
    // in between; returns a nominal request count (7, or 1 when the alloc fails).
    task automatic lifecycle(output int count);
        logic [4:0]        r;
        logic [ADDR_W-1:0] a;
        int                twist;
        a = pick_addr();
        count = 1;
        send_req(REQ_ALLOC, 5'd0, rand_addr());
        if (table_sb.last_status != ST_OK) return;
        r = table_sb.last_pick;
        send_req(REQ_BIND, r, a);
        if ($urandom_range(0, 1)) send_req(REQ_QUERY, r, rand_addr());
        send_req(REQ_FREE, r, rand_addr());
        count += 3;
        twist = $urandom_range(0, 7);
        case (twist)
            0: send_req(REQ_DIRTY, r, rand_addr());
            1: send_req(REQ_FORGET, r, a);
            2: send_req(REQ_CLEAR, r, rand_addr());
            default: ;
        endcase
        send_req(REQ_FIND, rand_reg(), a);
        send_req(REQ_QUERY, r, rand_addr());
        count += 3;
        if ($urandom_range(0, 1)) send_req(REQ_FREE, r, rand_addr());
    endtask

    // Random traffic: lifecycles on under half of the picks, the rest single requests of any code.
    task automatic random_traffic(int n_items);
        int sent;
        int cnt;
        int pick;
        logic [3:0] req;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 45) begin
                lifecycle(cnt);
                sent += cnt;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 3)       req = REQ_INIT;
                else if (pick < 8)  req = 4'($urandom_range(9, 15));
                else                req = 4'($urandom_range(1, 8));
                send_req(req, pick_reg(), pick_addr());
                sent++;
            end
        end
    endtask

    task automatic run_phase(logic [4:0] first, logic [4:0] last, logic [31:0] mask,
                             bit start_init, int n_items);
        drain();
        set_config(first, last, mask);
        if (start_init) send_req(REQ_INIT, rand_reg(), rand_addr());
        random_traffic(n_items);
    endtask

    // Main sequence: reset, directed requests, then configuration phases.
    initial begin : main_seq
        logic [4:0] f;
        logic [4:0] l;
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_FIRST_GENERAL;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_req_type  <= REQ_INIT;
        s_reg_index <= '0;
        s_mem_addr  <= '0;
        addr_pool[0] = 16'h0000;
        addr_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++) addr_pool[i] = rand_addr();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset configuration.
        send_req(REQ_QUERY, 5'd0, 16'h0000);
        send_req(REQ_INIT, 5'd31, 16'hFFFF);
        send_req(REQ_ALLOC, 5'd0, 16'h0000);
        send_req(REQ_ALLOC, 5'd0, 16'h0000);
        send_req(REQ_BIND, 5'd0, 16'hFFFF);
        send_req(REQ_BIND, 5'd1, 16'h0000);
        send_req(REQ_QUERY, 5'd0, 16'h0000);
        send_req(REQ_QUERY, 5'd31, 16'hFFFF);
        send_req(REQ_FREE, 5'd0, 16'h0000);
        send_req(REQ_FIND, 5'd0, 16'hFFFF);
        send_req(REQ_FIND, 5'd0, 16'h1234);
        send_req(REQ_FREE, 5'd1, 16'h0000);
        // Address zero matches only a bound entry.
        send_req(REQ_FIND, 5'd0, 16'h0000);
        send_req(REQ_FIND, 5'd0, 16'h0000);
        send_req(REQ_DIRTY, 5'd1, 16'h0000);
        send_req(REQ_QUERY, 5'd1, 16'h0000);
        send_req(REQ_CLEAR, 5'd0, 16'h0000);
        send_req(REQ_QUERY, 5'd0, 16'h0000);
        send_req(REQ_BIND, 5'd2, 16'hABCD);
        send_req(REQ_FORGET, 5'd0, 16'hABCD);
        send_req(REQ_QUERY, 5'd2, 16'h0000);
        send_req(4'd9, 5'd31, 16'hFFFF);
        send_req(4'd15, 5'd31, 16'hFFFF);

        // Every register reserved: allocation runs out at once.
        drain();
        set_config(5'd0, 5'd31, 32'hFFFF_FFFF);
        send_req(REQ_INIT, 5'd0, 16'h0000);
        send_req(REQ_ALLOC, 5'd0, 16'h0000);
        random_traffic(150);

        run_phase(5'd4, 5'd11, $urandom, 1'b1, 150);
        // Range moved without init: old bindings outside it must stay put.
        run_phase(5'd8, 5'd15, $urandom, 1'b0, 100);
        run_phase(5'd31, 5'd31, 32'h8000_0001, 1'b1, 120);
        run_phase(5'd20, 5'd5, $urandom, 1'b0, 100);
        run_phase(5'd0, 5'd0, 32'h0000_0000, 1'b1, 120);
        for (int p = 0; p < 4; p++) begin
            f = rand_reg();
            l = 5'($urandom_range(f, 31));
            run_phase(f, l, $urandom, 1'($urandom_range(0, 1)), 120);
        end

        drain();
        if (table_sb.errors == 0 && table_sb.pending() == 0)
            $display("register_binding_table_top test passed");
        else
            $display("register_binding_table_top test failed");
        $finish;
    end

endmodule
